// ===== src/fwts_pkg.sv =====
// fwts_pkg: shared constants, command and state encodings, and control structs
// for the fir filter with tail flush; no dependencies
package fwts_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int FRAC_BITS      = 15;
    localparam int IDX_BITS       = 4;
    localparam int NTAPS_BITS     = 5;
    localparam int TAPS_DEFAULT   = 16;
    localparam int NUM_TAPS_RESET = 16;
    localparam int CMD_BITS       = 2;
    localparam int IN_TDATA_BITS  = 40;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_RUN,
        S_DRAIN,
        S_FINISH
    } state_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic acc_clear;
        logic rd_valid;
        logic operand_ok;
    } mac_ctl_t;

    // sequencer to output register
    typedef struct packed {
        logic load;
        logic from_tail;
        logic tail_last;
    } res_t;

    function automatic int addr_w(int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== src/fwts_ram.sv =====
// fwts_ram: generic single-write, single-read memory with registered read data
// no dependencies
module fwts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/fwts_mac.sv =====
// fwts_mac: shared multiply-accumulate unit with rounding and saturation
// depends on fwts_pkg
module fwts_mac import fwts_pkg::*; #(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mac_ctl_t                      ctl,
    input  logic [COEF_BITS-1:0]          coef,
    input  logic [SAMPLE_BITS-1:0]        hist,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int AW    = addr_w(TAPS);
    localparam int PW    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W = PW + AW;
    localparam int SH_W  = ACC_W + 1 - FRAC_BITS;
    localparam int SAT_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SAT_MIN = -(1 << (SAMPLE_BITS - 1));

    logic signed [PW-1:0]    prod_reg;
    logic                    prod_v_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W:0]   rnd_sum;
    logic signed [SH_W-1:0]  shifted;

    // product stage, operands of never-written entries read as zero
    always_ff @(posedge clk)
    begin
        if (ctl.operand_ok)
        begin
            prod_reg <= $signed(coef) * $signed(hist);
        end
        else
        begin
            prod_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            prod_v_reg <= ctl.rd_valid;
            if (ctl.acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_v_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // round half up, floor shift, saturate
    always_comb
    begin
        rnd_sum = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(1 << (FRAC_BITS - 1));
        shifted = rnd_sum[ACC_W:FRAC_BITS];
        if (shifted > SH_W'(SAT_MAX))
        begin
            result = SAMPLE_BITS'(SAT_MAX);
        end
        else if (shifted < SH_W'(SAT_MIN))
        begin
            result = SAMPLE_BITS'(SAT_MIN);
        end
        else
        begin
            result = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ===== src/fwts_ctrl.sv =====
// fwts_ctrl: command decode and tap sequencer, history pointer, tail counter
// and valid bits; depends on fwts_pkg
module fwts_ctrl import fwts_pkg::*; #(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cmd_t                          command,
    input  logic [SAMPLE_BITS-1:0]        sample_in,
    input  logic [IDX_BITS-1:0]           coef_index,
    input  logic [NTAPS_BITS-1:0]         num_taps,
    input  logic                          out_busy,
    output logic                          hist_we,
    output logic [addr_w(TAPS)-1:0]       hist_waddr,
    output logic [SAMPLE_BITS-1:0]        hist_wdata,
    output logic [addr_w(TAPS)-1:0]       hist_raddr,
    output logic                          coef_we,
    output logic [addr_w(TAPS)-1:0]       coef_waddr,
    output logic [addr_w(TAPS)-1:0]       coef_raddr,
    output mac_ctl_t                      mac_ctl,
    output res_t                          res
);

    localparam int AW = addr_w(TAPS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TAPS - 1);
    localparam logic [NTAPS_BITS-1:0] TAIL_RST =
        NTAPS_BITS'(((NUM_TAPS_RESET > TAPS) ? TAPS : NUM_TAPS_RESET) - 1);

    state_t                  state_reg, state_next;
    logic [AW-1:0]           write_pos_reg;
    logic [AW-1:0]           hist_addr_reg;
    logic [AW-1:0]           coef_addr_reg;
    logic [NTAPS_BITS-1:0]   tail_left_reg;
    logic [NTAPS_BITS-1:0]   cnt_reg;
    logic                    drain_reg;
    logic                    from_tail_reg;
    logic                    tail_last_reg;
    logic [TAPS-1:0]         hist_vld_reg;
    logic [TAPS-1:0]         coef_vld_reg;
    logic                    rd_valid_reg;
    logic                    op_ok_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [NTAPS_BITS-1:0]   eff_taps;
    logic                    coef_in_range;

    always_comb
    begin
        if (num_taps == '0)
        begin
            eff_taps = NTAPS_BITS'(1);
        end
        else if (int'(num_taps) > TAPS)
        begin
            eff_taps = NTAPS_BITS'(TAPS);
        end
        else
        begin
            eff_taps = num_taps;
        end
    end

    assign coef_in_range = (int'(coef_index) < TAPS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == CMD_SAMPLE)
                    begin
                        state_next = S_WRITE;
                    end
                    else if (command == CMD_FLUSH && tail_left_reg != '0)
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!drain_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready           = (state_reg == S_IDLE);
        hist_we            = (state_reg == S_WRITE);
        hist_waddr         = write_pos_reg;
        hist_wdata         = sample_reg;
        hist_raddr         = hist_addr_reg;
        coef_we            = (state_reg == S_IDLE) && in_valid && (command == CMD_LOAD)
                             && coef_in_range;
        coef_waddr         = AW'(coef_index);
        coef_raddr         = coef_addr_reg;
        mac_ctl.acc_clear  = (state_reg == S_WRITE);
        mac_ctl.rd_valid   = rd_valid_reg;
        mac_ctl.operand_ok = op_ok_reg;
        res.load           = (state_reg == S_FINISH) && !out_busy;
        res.from_tail      = from_tail_reg;
        res.tail_last      = tail_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            write_pos_reg <= LAST_ADDR;
            hist_addr_reg <= '0;
            coef_addr_reg <= '0;
            tail_left_reg <= TAIL_RST;
            cnt_reg       <= '0;
            drain_reg     <= 1'b0;
            from_tail_reg <= 1'b0;
            tail_last_reg <= 1'b0;
            hist_vld_reg  <= '0;
            coef_vld_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            op_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == S_RUN);
            op_ok_reg    <= hist_vld_reg[hist_addr_reg] && coef_vld_reg[coef_addr_reg];
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (command)
                            CMD_SAMPLE:
                            begin
                                from_tail_reg <= 1'b0;
                                tail_last_reg <= 1'b0;
                            end
                            CMD_FLUSH:
                            begin
                                if (tail_left_reg != '0)
                                begin
                                    from_tail_reg <= 1'b1;
                                    tail_last_reg <= (tail_left_reg == NTAPS_BITS'(1));
                                    tail_left_reg <= tail_left_reg - NTAPS_BITS'(1);
                                end
                            end
                            CMD_LOAD:
                            begin
                                if (coef_in_range)
                                begin
                                    coef_vld_reg[coef_waddr] <= 1'b1;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                hist_vld_reg  <= '0;
                                write_pos_reg <= LAST_ADDR;
                                tail_left_reg <= eff_taps - NTAPS_BITS'(1);
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_WRITE:
                begin
                    // newest sample lands at write_pos, taps walk upward from there
                    hist_vld_reg[write_pos_reg] <= 1'b1;
                    hist_addr_reg <= write_pos_reg;
                    coef_addr_reg <= '0;
                    cnt_reg       <= eff_taps - NTAPS_BITS'(1);
                    write_pos_reg <= (write_pos_reg == '0) ? LAST_ADDR
                                     : write_pos_reg - AW'(1);
                end
                S_RUN:
                begin
                    hist_addr_reg <= (hist_addr_reg == LAST_ADDR) ? '0
                                     : hist_addr_reg + AW'(1);
                    coef_addr_reg <= (coef_addr_reg == LAST_ADDR) ? '0
                                     : coef_addr_reg + AW'(1);
                    cnt_reg       <= cnt_reg - NTAPS_BITS'(1);
                    drain_reg     <= 1'b1;
                end
                S_DRAIN:
                begin
                    drain_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // flush steps push a zero sample
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            sample_reg <= (command == CMD_SAMPLE) ? sample_in : '0;
        end
    end

endmodule

// ===== src/fir_filter_with_tail_flush.sv =====
// fir_filter_with_tail_flush: top level of the direct-form fir filter with tail flush
// depends on fwts_pkg, fwts_ram, fwts_mac and fwts_ctrl
//
// Direct-form FIR filter, Q1.15, over a circular history of TAPS samples. Each input
// transaction carries a command in s_axis_tuser: sample (push sample_in and emit one
// filtered result), flush step (push a zero and emit one tail result while the tail
// counter is above zero, else nothing), load coefficient, or clear history (zero the
// history, reload the tail counter to the effective tap count minus one). The tap count
// comes from the num_taps register, written through cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle, and the block does not enforce this. 0 acts
// as 1 and values above TAPS act as TAPS. Writing it does not reload the tail counter.
// A single multiplier and accumulator are walked over the taps, one tap per clock,
// reading coefficient and history memories: a sample or flush transaction passes the
// write, run, drain and finish states before s_axis_tready returns, and its result is
// loaded on leaving finish. Load, clear and empty flushes end in idle. The result sits
// in an output register, so the next transaction is accepted while it waits; the block
// stalls only when a new result is ready and the previous one has not been taken.
// Accumulation is exact; the sum is rounded half up at bit 15 and saturated to 16 bits.
module fir_filter_with_tail_flush import fwts_pkg::*; #(
    parameter int TAPS = TAPS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // input transactions
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,  // sample_in[15:0], coef_index[19:16],
                                                    // coef_value[35:20], zero pad
    input  logic [CMD_BITS-1:0]      s_axis_tuser,  // command
    // result transactions
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [SAMPLE_BITS-1:0]   m_axis_tdata,  // sample_out
    output logic                     m_axis_tuser,  // from_tail
    output logic                     m_axis_tlast,  // tail_last
    // tap count register
    input  logic                     cfg_wr_en,
    input  logic [NTAPS_BITS-1:0]    cfg_wr_data
);

    localparam int AW = addr_w(TAPS);

    logic [NTAPS_BITS-1:0]          num_taps_reg;
    logic                           m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]         m_tdata_reg;
    logic                           m_tuser_reg;
    logic                           m_tlast_reg;

    logic                           out_busy;
    logic                           hist_we;
    logic [AW-1:0]                  hist_waddr;
    logic [SAMPLE_BITS-1:0]         hist_wdata;
    logic [AW-1:0]                  hist_raddr;
    logic [SAMPLE_BITS-1:0]         hist_rdata;
    logic                           coef_we;
    logic [AW-1:0]                  coef_waddr;
    logic [AW-1:0]                  coef_raddr;
    logic [COEF_BITS-1:0]           coef_rdata;
    mac_ctl_t                       mac_ctl;
    res_t                           res;
    logic signed [SAMPLE_BITS-1:0]  mac_result;

    // unpacked input fields
    logic [SAMPLE_BITS-1:0]         in_sample;
    logic [IDX_BITS-1:0]            in_coef_index;
    logic [COEF_BITS-1:0]           in_coef_value;

    assign in_sample     = s_axis_tdata[SAMPLE_BITS-1:0];
    assign in_coef_index = s_axis_tdata[SAMPLE_BITS+IDX_BITS-1:SAMPLE_BITS];
    assign in_coef_value = s_axis_tdata[SAMPLE_BITS+IDX_BITS+COEF_BITS-1:SAMPLE_BITS+IDX_BITS];

    // output register holds one result until taken
    assign out_busy = m_tvalid_reg && !m_axis_tready;

    fwts_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .command    (cmd_t'(s_axis_tuser)),
        .sample_in  (in_sample),
        .coef_index (in_coef_index),
        .num_taps   (num_taps_reg),
        .out_busy   (out_busy),
        .hist_we    (hist_we),
        .hist_waddr (hist_waddr),
        .hist_wdata (hist_wdata),
        .hist_raddr (hist_raddr),
        .coef_we    (coef_we),
        .coef_waddr (coef_waddr),
        .coef_raddr (coef_raddr),
        .mac_ctl    (mac_ctl),
        .res        (res)
    );

    // sample history, circular, newest at the write pointer
    fwts_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (TAPS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .raddr (hist_raddr),
        .rdata (hist_rdata)
    );

    // coefficient store, written straight from load transactions
    fwts_ram #(
        .WIDTH (COEF_BITS),
        .DEPTH (TAPS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (in_coef_value),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    fwts_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .coef   (coef_rdata),
        .hist   (hist_rdata),
        .result (mac_result)
    );

    // tap count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg <= NTAPS_BITS'(NUM_TAPS_RESET);
        end
        else if (cfg_wr_en)
        begin
            num_taps_reg <= cfg_wr_data;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            m_tdata_reg <= mac_result;
            m_tuser_reg <= res.from_tail;
            m_tlast_reg <= res.tail_last;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tlast  = m_tlast_reg;

    // a new result never overwrites one that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        res.load |-> !(m_tvalid_reg && !m_axis_tready))
    else $error("result loaded over a pending result");

    // only a flush step can empty the tail
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("tail_last set on a result not from a flush step");

    // no tap is still in flight when a new transaction can be accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !mac_ctl.rd_valid)
    else $error("accumulation still running while ready");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for fir_filter_with_tail_flush
// uses fwts_pkg for the command codes and port widths, and the dut fir_filter_with_tail_flush
module testbench;
    import fwts_pkg::*;

    // one input transaction and one result transaction
    typedef struct {
        cmd_t        cmd;
        logic [15:0] sample;
        logic [3:0]  idx;
        logic [15:0] coef;
    } fir_item_t;

    typedef struct {
        logic [15:0] value;
        logic        from_tail;
        logic        tail_last;
    } fir_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;
    logic [CMD_BITS-1:0]      s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [SAMPLE_BITS-1:0]   m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     m_axis_tlast;
    logic                     cfg_wr_en = 1'b0;
    logic [NTAPS_BITS-1:0]    cfg_wr_data = '0;

    // filter state as the bench sees it
    logic signed [15:0] hist_mem [16];
    logic signed [15:0] coef_mem [16];
    logic [3:0]         newest_pos;
    logic [4:0]         tail_cnt;
    logic [4:0]         taps_reg;

    fir_item_t   pending_cmds [$];   // items waiting for the driver
    fir_result_t expected_samples [$];
    fir_item_t   on_wire;            // item currently offered on the slave side
    bit          steady = 1'b0;      // no random idling on either side
    int          error_count = 0;
    int          results_seen = 0;
    int          hold_left = 0;

    fir_filter_with_tail_flush i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #4 clk = ~clk;

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // tap count in use: 0 acts as 1, anything above 16 acts as 16
    function automatic int active_taps(input logic [4:0] v);
        if (v == 0)
            return 1;
        if (v > 16)
            return 16;
        return v;
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < 16; i++)
            hist_mem[i] = '0;
        newest_pos = 4'd15;
        tail_cnt = 5'(active_taps(taps_reg) - 1);
    endfunction

    // store one sample and return the rounded, saturated dot product
    function automatic logic [15:0] filter_push(input logic signed [15:0] x);
        logic signed [63:0] acc;
        logic signed [63:0] c;
        logic signed [63:0] h;
        logic signed [63:0] y;
        logic [3:0]         j;
        int                 n;
        n = active_taps(taps_reg);
        hist_mem[newest_pos] = x;
        acc = '0;
        for (int k = 0; k < n; k++)
        begin
            j = newest_pos + 4'(k);
            c = coef_mem[k];
            h = hist_mem[j];
            acc = acc + c * h;
        end
        // round half up at bit 15, then clamp to q1.15
        y = (acc + 64'sd16384) >>> 15;
        if (y > 64'sd32767)
            y = 64'sd32767;
        if (y < -64'sd32768)
            y = -64'sd32768;
        newest_pos = newest_pos - 4'd1;
        return y[15:0];
    endfunction

    // apply one accepted transaction and queue the result it causes, if any
    task automatic filter_step(input fir_item_t it);
        fir_result_t r;
        case (it.cmd)
            CMD_SAMPLE:
            begin
                r.value = filter_push(it.sample);
                r.from_tail = 1'b0;
                r.tail_last = 1'b0;
                expected_samples.push_back(r);
            end
            CMD_FLUSH:
            begin
                // empty tail: nothing changes, nothing comes out
                if (tail_cnt != 0)
                begin
                    r.value = filter_push(16'sd0);
                    tail_cnt = tail_cnt - 5'd1;
                    r.from_tail = 1'b1;
                    r.tail_last = (tail_cnt == 0);
                    expected_samples.push_back(r);
                end
            end
            CMD_LOAD:
                coef_mem[it.idx] = it.coef;
            default:
                clear_history();
        endcase
    endtask

    function automatic fir_item_t make_item(input cmd_t c, input logic [15:0] s,
                                            input logic [3:0] i, input logic [15:0] cv);
        fir_item_t it;
        it.cmd = c;
        it.sample = s;
        it.idx = i;
        it.coef = cv;
        return it;
    endfunction

    // data word biased toward the extremes and toward small values
    function automatic logic [15:0] pick_word();
        logic [10:0] v;
        v = 11'($urandom);
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2, 3: return {{5{v[10]}}, v};
            default: return 16'($urandom);
        endcase
    endfunction

    // every field random, so unused fields toggle as well
    function automatic fir_item_t rand_item(input cmd_t c);
        return make_item(c, pick_word(), 4'($urandom), pick_word());
    endfunction

    // mostly samples, with clear-and-drain sequences and some noise
    task automatic add_traffic(input int count);
        int r;
        int n;
        int k;
        k = 0;
        while (k < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                pending_cmds.push_back(rand_item(CMD_SAMPLE));
            else if (r < 67)
                pending_cmds.push_back(rand_item(CMD_FLUSH));
            else if (r < 80)
                pending_cmds.push_back(rand_item(CMD_LOAD));
            else if (r < 92)
            begin
                // clear, then flush the whole tail and two steps past it
                n = active_taps(taps_reg);
                pending_cmds.push_back(rand_item(CMD_CLEAR));
                repeat (n + 1)
                    pending_cmds.push_back(rand_item(CMD_FLUSH));
                k += n + 1;
            end
            else
                pending_cmds.push_back(rand_item(cmd_t'($urandom_range(0, 3))));
            k++;
        end
    endtask

    // wait until everything queued has gone through the block
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
            @(posedge clk);
        // load, clear and empty flush leave no result; let any work finish
        repeat (24) @(posedge clk);
    endtask

    task automatic write_taps(input logic [4:0] v);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        taps_reg = v;
    endtask

    // driver: offers the next pending item, predicts on every accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            s_axis_tuser <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                filter_step(on_wire);
            // a held item stays put until taken
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_cmds.size() != 0 && (steady || $urandom_range(0, 99) >= 35))
                begin
                    on_wire = pending_cmds.pop_front();
                    s_axis_tdata <= {4'b0, on_wire.coef, on_wire.idx, on_wire.sample};
                    s_axis_tuser <= on_wire.cmd;
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each result transaction and drives the receiver's ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (expected_samples.size() == 0)
                    flag_error($sformatf("result %0d with nothing expected (data %h)",
                                         results_seen, m_axis_tdata));
                else
                begin
                    fir_result_t want;
                    want = expected_samples.pop_front();
                    if (m_axis_tdata !== want.value)
                        flag_error($sformatf("result %0d sample_out %0d, expected %0d",
                                             results_seen, $signed(m_axis_tdata),
                                             $signed(want.value)));
                    if (m_axis_tuser !== want.from_tail)
                        flag_error($sformatf("result %0d from_tail %b, expected %b",
                                             results_seen, m_axis_tuser, want.from_tail));
                    if (m_axis_tlast !== want.tail_last)
                        flag_error($sformatf("result %0d tail_last %b, expected %b",
                                             results_seen, m_axis_tlast, want.tail_last));
                end
                // one long hold-off so the block backs up into its input
                if (results_seen == 150)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    initial
    begin
        int phase_taps [10];
        int guard;
        phase_taps = '{1, 16, 17, 7, 0, 3, 31, 12, 5, 16};
        taps_reg = 5'(NUM_TAPS_RESET);
        for (int i = 0; i < 16; i++)
            coef_mem[i] = '0;
        clear_history();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset tap count: coefficient and sample extremes, one tail step
        pending_cmds.push_back(make_item(CMD_LOAD, 16'h0000, 4'd0, 16'h7fff));
        pending_cmds.push_back(make_item(CMD_LOAD, 16'h0000, 4'd1, 16'h8000));
        pending_cmds.push_back(make_item(CMD_LOAD, 16'h0000, 4'd15, 16'h4000));
        pending_cmds.push_back(make_item(CMD_LOAD, 16'h0000, 4'd2, 16'hffff));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h7fff, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h8000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h0001, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'hffff, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_FLUSH, 16'h0000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_CLEAR, 16'h0000, 4'd0, 16'h0000));

        // two taps: saturation both ways, tail drained to empty and past it
        write_taps(5'd2);
        pending_cmds.push_back(make_item(CMD_LOAD, 16'h0000, 4'd0, 16'h8000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h8000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h8000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h7fff, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h7fff, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_CLEAR, 16'h0000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_FLUSH, 16'h0000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_FLUSH, 16'h0000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_FLUSH, 16'h0000, 4'd0, 16'h0000));

        // tap count zero acts as one, above sixteen acts as sixteen
        write_taps(5'd0);
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h8000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_CLEAR, 16'h0000, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_FLUSH, 16'h0000, 4'd0, 16'h0000));
        write_taps(5'd31);
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h7fff, 4'd0, 16'h0000));
        pending_cmds.push_back(make_item(CMD_SAMPLE, 16'h1234, 4'd0, 16'h0000));

        // random phases, one tap count each; the first runs without idling
        for (int p = 0; p < 10; p++)
        begin
            write_taps(5'(phase_taps[p]));
            steady = (p == 0);
            add_traffic(110);
        end

        while (pending_cmds.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        guard = 0;
        while (expected_samples.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        if (expected_samples.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_samples.size()));

        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // watchdog far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("timeout waiting for the block");
        $display("testbench: FAIL");
        $finish;
    end

endmodule
